### src/tds_pkg.sv
package tds_pkg;

  localparam int NODE_W        = 6;
  localparam int CNT_W         = 7;
  localparam int SUM_W         = 11;
  localparam int MAX_NODES_DEF = 64;

  localparam logic [CNT_W-1:0] NODE_COUNT_RST = 7'd64;

  typedef struct packed {
    logic [NODE_W-1:0] end_a;
    logic [NODE_W-1:0] end_b;
    logic              last_edge;
  } in_item_t;

  typedef struct packed {
    logic [NODE_W-1:0] node_index;
    logic [SUM_W-1:0]  distance_sum;
    logic              last_result;
  } out_item_t;

  // datapath operations, one per cycle
  typedef enum logic [4:0] {
    OP_NOP,
    OP_LOAD,
    OP_INIT,
    OP_HEAD_RD,
    OP_U_LAT,
    OP_SCAN_RD,
    OP_SCAN_CHK,
    OP_UP_INIT,
    OP_UP_RD0,
    OP_UP_RD1,
    OP_UP_RD2,
    OP_UP_WR,
    OP_RR_INIT,
    OP_RR_ROOT,
    OP_RR_RD0,
    OP_RR_RD1,
    OP_RR_RD2,
    OP_RR_WR,
    OP_EM_INIT,
    OP_EM_RD,
    OP_EM_LD,
    OP_EM_WAIT
  } tds_op_t;

  typedef struct packed {
    logic head_done;
    logic scan_done;
    logic up_done;
    logic rr_done;
    logic out_taken;
    logic emit_last;
  } tds_stat_t;

endpackage

### src/tds_ctrl.sv
module tds_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_last,
  input  tds_pkg::tds_stat_t stat,
  output logic               in_ready,
  output tds_pkg::tds_op_t   op
);

  typedef enum logic [4:0] {
    S_IDLE, S_INIT, S_HEAD, S_HLAT, S_SCAN, S_SCHK,
    S_UPI, S_UP0, S_UP1, S_UP2, S_UP3,
    S_RRI, S_RRR, S_RR0, S_RR1, S_RR2, S_RR3,
    S_EMI, S_EMR, S_EML, S_EMW
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    op        = tds_pkg::OP_NOP;
    unique case (state_r)
      S_IDLE: begin
        op = tds_pkg::OP_LOAD;
        if (in_valid && in_last) state_nxt = S_INIT;
      end
      S_INIT: begin
        op        = tds_pkg::OP_INIT;
        state_nxt = S_HEAD;
      end
      S_HEAD: begin
        if (stat.head_done) begin
          state_nxt = S_UPI;
        end else begin
          op        = tds_pkg::OP_HEAD_RD;
          state_nxt = S_HLAT;
        end
      end
      S_HLAT: begin
        op        = tds_pkg::OP_U_LAT;
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (stat.scan_done) begin
          state_nxt = S_HEAD;
        end else begin
          op        = tds_pkg::OP_SCAN_RD;
          state_nxt = S_SCHK;
        end
      end
      S_SCHK: begin
        op        = tds_pkg::OP_SCAN_CHK;
        state_nxt = S_SCAN;
      end
      S_UPI: begin
        op        = tds_pkg::OP_UP_INIT;
        state_nxt = S_UP0;
      end
      S_UP0: begin
        if (stat.up_done) begin
          state_nxt = S_RRI;
        end else begin
          op        = tds_pkg::OP_UP_RD0;
          state_nxt = S_UP1;
        end
      end
      S_UP1: begin
        op        = tds_pkg::OP_UP_RD1;
        state_nxt = S_UP2;
      end
      S_UP2: begin
        op        = tds_pkg::OP_UP_RD2;
        state_nxt = S_UP3;
      end
      S_UP3: begin
        op        = tds_pkg::OP_UP_WR;
        state_nxt = S_UP0;
      end
      S_RRI: begin
        op        = tds_pkg::OP_RR_INIT;
        state_nxt = S_RRR;
      end
      S_RRR: begin
        op        = tds_pkg::OP_RR_ROOT;
        state_nxt = S_RR0;
      end
      S_RR0: begin
        if (stat.rr_done) begin
          state_nxt = S_EMI;
        end else begin
          op        = tds_pkg::OP_RR_RD0;
          state_nxt = S_RR1;
        end
      end
      S_RR1: begin
        op        = tds_pkg::OP_RR_RD1;
        state_nxt = S_RR2;
      end
      S_RR2: begin
        op        = tds_pkg::OP_RR_RD2;
        state_nxt = S_RR3;
      end
      S_RR3: begin
        op        = tds_pkg::OP_RR_WR;
        state_nxt = S_RR0;
      end
      S_EMI: begin
        op        = tds_pkg::OP_EM_INIT;
        state_nxt = S_EMR;
      end
      S_EMR: begin
        op        = tds_pkg::OP_EM_RD;
        state_nxt = S_EML;
      end
      S_EML: begin
        op        = tds_pkg::OP_EM_LD;
        state_nxt = S_EMW;
      end
      S_EMW: begin
        op = tds_pkg::OP_EM_WAIT;
        if (stat.out_taken) state_nxt = stat.emit_last ? S_IDLE : S_EMR;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### src/tds_datapath.sv
module tds_datapath #(
  parameter int MAX_NODES = tds_pkg::MAX_NODES_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  tds_pkg::tds_op_t           op,
  output tds_pkg::tds_stat_t         stat,
  input  logic                       in_fire,
  input  tds_pkg::in_item_t          in_data,
  input  logic                       cfg_we,
  input  logic [tds_pkg::CNT_W-1:0]  cfg_wdata,
  output logic                       out_valid,
  input  logic                       out_ready,
  output tds_pkg::out_item_t         out_data
);

  localparam int NW = tds_pkg::NODE_W;
  localparam int KW = tds_pkg::CNT_W;
  localparam int SW = tds_pkg::SUM_W;
  localparam int CW = $clog2(MAX_NODES + 1);
  localparam int IW = $clog2(MAX_NODES);
  localparam int EW = (MAX_NODES > 2) ? $clog2(MAX_NODES - 1) : 1;
  localparam int ED = MAX_NODES - 1;

  // edge store and working stores
  logic [NW-1:0] ef_mem [ED];
  logic [NW-1:0] es_mem [ED];
  logic [NW-1:0] vo_mem [MAX_NODES];
  logic [NW-1:0] par_mem [MAX_NODES];
  logic [CW-1:0] sub_mem [MAX_NODES];
  logic [SW-1:0] ds_mem [MAX_NODES];
  logic [SW-1:0] ans_mem [MAX_NODES];

  logic [NW-1:0] rd_ef, rd_es, rd_vo, rd_par;
  logic [CW-1:0] rd_sub;
  logic [SW-1:0] rd_ds, rd_ans;

  logic [KW-1:0]        node_count_r;
  logic [CW-1:0]        ecnt_r, head_r, tail_r, scan_r, idx_r, n_r, k_r;
  logic [NW-1:0]        u_r, c_r, p_r;
  logic [CW-1:0]        csub_r;
  logic [SW-1:0]        cds_r;
  logic [MAX_NODES-1:0] seen_r;
  logic                 out_valid_r;
  tds_pkg::out_item_t   out_data_r;

  // memory port controls
  logic          vo_we, par_we, sub_we, ds_we, ans_we, e_we;
  logic [IW-1:0] vo_wa, par_wa, sub_wa, ds_wa, ans_wa;
  logic [NW-1:0] vo_wd;
  logic [CW-1:0] sub_wd;
  logic [SW-1:0] ds_wd, ans_wd;
  logic [IW-1:0] vo_ra, par_ra, sub_ra, ds_ra, ans_ra;

  // edge check
  logic          e_ok, hit_a, hit_b, add_v;
  logic [NW-1:0] v_id;
  logic [CW-1:0] n_sat;

  always_comb begin
    if (node_count_r < KW'(2))              n_sat = CW'(2);
    else if (node_count_r > KW'(MAX_NODES)) n_sat = CW'(MAX_NODES);
    else                                    n_sat = CW'(node_count_r);
  end

  always_comb begin
    e_ok  = (KW'(rd_ef) < KW'(n_r)) && (KW'(rd_es) < KW'(n_r));
    hit_a = (rd_ef == u_r);
    hit_b = (rd_es == u_r);
    v_id  = hit_a ? rd_es : rd_ef;
    add_v = e_ok && (hit_a || hit_b) && !seen_r[v_id[IW-1:0]]
            && (tail_r != CW'(MAX_NODES));
  end

  always_comb begin
    stat.head_done = (head_r == tail_r);
    stat.scan_done = (scan_r == ecnt_r);
    stat.up_done   = (idx_r == '0);
    stat.rr_done   = (idx_r == tail_r);
    stat.out_taken = out_valid_r && out_ready;
    stat.emit_last = ((KW'(k_r) + KW'(1)) == KW'(n_r));
  end

  always_comb begin
    e_we   = (op == tds_pkg::OP_LOAD) && in_fire && (ecnt_r != CW'(ED));
    vo_we  = 1'b0;
    vo_wa  = '0;
    vo_wd  = '0;
    par_we = 1'b0;
    par_wa = v_id[IW-1:0];
    sub_we = 1'b0;
    sub_wa = '0;
    sub_wd = CW'(1);
    ds_we  = 1'b0;
    ds_wa  = '0;
    ds_wd  = '0;
    ans_we = 1'b0;
    ans_wa = '0;
    ans_wd = '0;
    vo_ra  = idx_r[IW-1:0];
    par_ra = rd_vo[IW-1:0];
    sub_ra = rd_vo[IW-1:0];
    ds_ra  = rd_vo[IW-1:0];
    ans_ra = k_r[IW-1:0];
    unique case (op)
      tds_pkg::OP_INIT: begin
        vo_we  = 1'b1;
        sub_we = 1'b1;
        ds_we  = 1'b1;
      end
      tds_pkg::OP_HEAD_RD: vo_ra = head_r[IW-1:0];
      tds_pkg::OP_SCAN_CHK: begin
        vo_we  = add_v;
        vo_wa  = tail_r[IW-1:0];
        vo_wd  = v_id;
        par_we = add_v;
        sub_we = add_v;
        sub_wa = v_id[IW-1:0];
        ds_we  = add_v;
        ds_wa  = v_id[IW-1:0];
      end
      tds_pkg::OP_UP_RD2: begin
        sub_ra = rd_par[IW-1:0];
        ds_ra  = rd_par[IW-1:0];
      end
      tds_pkg::OP_UP_WR: begin
        sub_we = 1'b1;
        sub_wa = p_r[IW-1:0];
        sub_wd = rd_sub + csub_r;
        ds_we  = 1'b1;
        ds_wa  = p_r[IW-1:0];
        ds_wd  = rd_ds + cds_r + SW'(csub_r);
      end
      tds_pkg::OP_RR_INIT: ds_ra = '0;
      tds_pkg::OP_RR_ROOT: begin
        ans_we = 1'b1;
        ans_wd = rd_ds;
      end
      tds_pkg::OP_RR_RD2: ans_ra = rd_par[IW-1:0];
      tds_pkg::OP_RR_WR: begin
        ans_we = 1'b1;
        ans_wa = c_r[IW-1:0];
        ans_wd = rd_ans + SW'(tail_r) - SW'({csub_r, 1'b0});
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (e_we) begin
      ef_mem[ecnt_r[EW-1:0]] <= in_data.end_a;
      es_mem[ecnt_r[EW-1:0]] <= in_data.end_b;
    end
    rd_ef <= ef_mem[scan_r[EW-1:0]];
    rd_es <= es_mem[scan_r[EW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (vo_we) vo_mem[vo_wa] <= vo_wd;
    rd_vo <= vo_mem[vo_ra];
  end

  always_ff @(posedge clk) begin
    if (par_we) par_mem[par_wa] <= u_r;
    rd_par <= par_mem[par_ra];
  end

  always_ff @(posedge clk) begin
    if (sub_we) sub_mem[sub_wa] <= sub_wd;
    rd_sub <= sub_mem[sub_ra];
  end

  always_ff @(posedge clk) begin
    if (ds_we) ds_mem[ds_wa] <= ds_wd;
    rd_ds <= ds_mem[ds_ra];
  end

  always_ff @(posedge clk) begin
    if (ans_we) ans_mem[ans_wa] <= ans_wd;
    rd_ans <= ans_mem[ans_ra];
  end

  // counters and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= tds_pkg::NODE_COUNT_RST;
      ecnt_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) node_count_r <= cfg_wdata;
      if (e_we) ecnt_r <= ecnt_r + CW'(1);
      if (op == tds_pkg::OP_EM_LD) out_valid_r <= 1'b1;
      if (op == tds_pkg::OP_EM_WAIT && stat.out_taken) begin
        out_valid_r <= 1'b0;
        if (stat.emit_last) ecnt_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (op)
      tds_pkg::OP_INIT: begin
        seen_r    <= MAX_NODES'(1);
        head_r    <= '0;
        tail_r    <= CW'(1);
        n_r       <= n_sat;
      end
      tds_pkg::OP_HEAD_RD: head_r <= head_r + CW'(1);
      tds_pkg::OP_U_LAT: begin
        u_r    <= rd_vo;
        scan_r <= '0;
      end
      tds_pkg::OP_SCAN_RD: scan_r <= scan_r + CW'(1);
      tds_pkg::OP_SCAN_CHK: begin
        if (add_v) begin
          seen_r[v_id[IW-1:0]] <= 1'b1;
          tail_r               <= tail_r + CW'(1);
        end
      end
      tds_pkg::OP_UP_INIT: idx_r <= tail_r - CW'(1);
      tds_pkg::OP_UP_RD1, tds_pkg::OP_RR_RD1: c_r <= rd_vo;
      tds_pkg::OP_UP_RD2, tds_pkg::OP_RR_RD2: begin
        p_r    <= rd_par;
        csub_r <= rd_sub;
        cds_r  <= rd_ds;
      end
      tds_pkg::OP_UP_WR: idx_r <= idx_r - CW'(1);
      tds_pkg::OP_RR_INIT: idx_r <= CW'(1);
      tds_pkg::OP_RR_WR: idx_r <= idx_r + CW'(1);
      tds_pkg::OP_EM_INIT: k_r <= '0;
      tds_pkg::OP_EM_LD: begin
        out_data_r.node_index   <= NW'(k_r);
        out_data_r.distance_sum <= seen_r[k_r[IW-1:0]] ? rd_ans : '0;
        out_data_r.last_result  <= stat.emit_last;
      end
      tds_pkg::OP_EM_WAIT: begin
        if (stat.out_taken && !stat.emit_last) k_r <= k_r + CW'(1);
      end
      default: ;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### src/tree_distance_sum.sv
// tree_distance_sum: sum of distances from every node of a tree
//
// input channel: one tree edge per item (end_a, end_b, last_edge), taken one
// per cycle while the block is loading; edges beyond the store depth are
// dropped. the item with last_edge set closes the tree and starts the solve;
// in_ready stays low from then until the last result item has been taken.
// result channel: one item per node 0 .. node_count-1 in ascending order,
// last_result set on the final one. nodes not reachable from node 0 give 0.
// config: cfg_we/cfg_wdata write node_count (saturated to 2 .. MAX_NODES);
// the user must write it only while the block is loading, the block itself
// does not enforce this. after the last edge the block orders the reached
// nodes breadth-first from node 0, comparing each stored edge against the
// current node through the edge store's registered read, then runs the
// leaves-first pass and rerooting, then emits one result item per node
// through the answer store's registered read.
// a stalled receiver simply holds the output register; emission waits.
// reset (synchronous, rst_n low) clears the edge count, drops any pending
// result and sets node_count back to 64; the stores need no clearing.
module tree_distance_sum #(
  parameter int MAX_NODES = tds_pkg::MAX_NODES_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  tds_pkg::in_item_t         in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output tds_pkg::out_item_t        out_data,
  input  logic                      cfg_we,
  input  logic [tds_pkg::CNT_W-1:0] cfg_wdata
);

  tds_pkg::tds_op_t   op;
  tds_pkg::tds_stat_t stat;

  // sequencer: loading, ordering, both passes and emission
  tds_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_last  (in_data.last_edge),
    .stat     (stat),
    .in_ready (in_ready),
    .op       (op)
  );

  // stores, counters, adders and the output register
  tds_datapath #(
    .MAX_NODES (MAX_NODES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .op        (op),
    .stat      (stat),
    .in_fire   (in_valid && in_ready),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

### src/tds_checker.sv
module tds_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input tds_pkg::out_item_t out_data
);

  // loading and emitting never overlap
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input ready while a result item is pending");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result item changed");

  // after the final result the block returns to loading
  a_last_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_data.last_result |=> !out_valid && in_ready)
    else $error("block did not return to loading after last result");

  // mid-sequence results keep the input closed
  a_mid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_data.last_result |=> !in_ready)
    else $error("input opened before the last result");

endmodule

bind tree_distance_sum tds_checker u_tds_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

### tb/tree_distance_sum_tb.sv
module tree_distance_sum_tb;

  localparam int MAXN = tds_pkg::MAX_NODES_DEF;
  localparam int NW = tds_pkg::NODE_W;
  localparam int KW = tds_pkg::CNT_W;
  localparam int SW = tds_pkg::SUM_W;
  localparam int WATCHDOG_LIMIT = 40000;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  tds_pkg::in_item_t in_data;
  logic out_valid;
  logic out_ready;
  tds_pkg::out_item_t out_data;
  logic cfg_we;
  logic [KW-1:0] cfg_wdata;

  tree_distance_sum DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  // predictor state: count register and the edges stored so far
  logic [KW-1:0] node_count_reg;
  logic [NW-1:0] edge_a_store [MAXN-1];
  logic [NW-1:0] edge_b_store [MAXN-1];
  int edges_held;

  // expected result items, oldest first
  tds_pkg::out_item_t sums_expected[$];

  int errors = 0;
  int idle_cycles = 0;
  int stall_left = 0;
  bit no_idle;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // breadth-first spanning tree from node 0, then leaves-first sizes and rerooting
  task automatic solve_tree();
    int n, head, tail, u, v, a, b, c, p;
    bit seen [MAXN];
    int order [MAXN];
    int par [MAXN];
    int cnt [MAXN];
    int dsum [MAXN];
    int ans [MAXN];
    tds_pkg::out_item_t r;
    if (node_count_reg < 2) n = 2;
    else if (node_count_reg > MAXN) n = MAXN;
    else n = node_count_reg;
    for (int i = 0; i < MAXN; i++) begin
      seen[i] = 0; ans[i] = 0; cnt[i] = 0; dsum[i] = 0; par[i] = 0;
    end
    seen[0] = 1; order[0] = 0; head = 0; tail = 1;
    while (head < tail) begin
      u = order[head];
      head++;
      for (int e = 0; e < edges_held; e++) begin
        a = edge_a_store[e]; b = edge_b_store[e];
        if (a >= n || b >= n) continue;
        if (a == u) v = b;
        else if (b == u) v = a;
        else continue;
        if (seen[v] || tail >= MAXN) continue;
        seen[v] = 1; order[tail] = v; par[v] = u; tail++;
      end
    end
    for (int i = 0; i < tail; i++) begin
      cnt[order[i]] = 1; dsum[order[i]] = 0;
    end
    for (int i = tail - 1; i >= 1; i--) begin
      c = order[i]; p = par[c];
      cnt[p] += cnt[c];
      dsum[p] += dsum[c] + cnt[c];
    end
    ans[0] = dsum[0];
    for (int i = 1; i < tail; i++) begin
      c = order[i];
      ans[c] = ans[par[c]] + tail - 2 * cnt[c];
    end
    for (int k = 0; k < n; k++) begin
      r.node_index = k[NW-1:0];
      r.distance_sum = ans[k][SW-1:0];
      r.last_result = (k == n - 1);
      sums_expected = {sums_expected, r};
    end
  endtask

  task automatic take_edge(input tds_pkg::in_item_t it);
    if (edges_held < MAXN - 1) begin
      edge_a_store[edges_held] = it.end_a;
      edge_b_store[edges_held] = it.end_b;
      edges_held++;
    end
    if (it.last_edge) begin
      solve_tree();
      edges_held = 0;
    end
  endtask

  // drive one item and wait for acceptance; random idle bursts before it
  task automatic send_edge(input tds_pkg::in_item_t it);
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    take_edge(it);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (sums_expected.size() != 0);
  endtask

  // config only while idle, once every result is back
  task automatic write_count(input logic [KW-1:0] val);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    node_count_reg = val;
  endtask

  // random tree on the first n nodes, maybe with noise edges
  task automatic send_tree(input int n, input bit noisy);
    tds_pkg::in_item_t it;
    int m;
    m = n - 1;
    for (int i = 1; i <= m; i++) begin
      it.end_a = NW'($urandom_range(0, i - 1));
      it.end_b = NW'(i);
      if ($urandom_range(0, 1)) begin
        it.end_a = NW'(i); it.end_b = NW'($urandom_range(0, i - 1));
      end
      if (noisy && $urandom_range(0, 5) == 0) begin
        it.end_a = NW'($urandom); it.end_b = NW'($urandom);
      end
      it.last_edge = (i == m) && !(noisy && $urandom_range(0, 3) == 0);
      send_edge(it);
    end
    if (noisy && !it.last_edge) begin
      it.end_a = NW'($urandom); it.end_b = NW'($urandom); it.last_edge = 1'b1;
      send_edge(it);
    end
  endtask

  // directed rows: a, b, last
  typedef struct {
    logic [NW-1:0] a;
    logic [NW-1:0] b;
    logic last;
  } edge_row_t;

  edge_row_t dir_rows [6] = '{
    '{6'd0, 6'd1, 1'b1},   // single edge
    '{6'd0, 6'd0, 1'b1},   // loop only
    '{6'd63, 6'd63, 1'b1}, // endpoints out of range at count 2
    '{6'd0, 6'd1, 1'b0},   // repeated edge
    '{6'd1, 6'd0, 1'b1},
    '{6'd2, 6'd3, 1'b1}    // node 0 isolated
  };

  // result side: random stall bursts on out_ready
  always @(negedge clk) begin
    if (no_idle) begin
      stall_left <= 0;
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 3) == 0) begin
      stall_left <= $urandom_range(0, 9);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // field compare against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (sums_expected.size() == 0) begin
        $error("unexpected result item node_index=%0d", out_data.node_index);
        errors++;
      end else begin
        tds_pkg::out_item_t e;
        e = sums_expected.pop_front();
        if (out_data.node_index !== e.node_index) begin
          $error("node_index exp %0d got %0d", e.node_index, out_data.node_index);
          errors++;
        end
        if (out_data.distance_sum !== e.distance_sum) begin
          $error("distance_sum exp %0d got %0d", e.distance_sum, out_data.distance_sum);
          errors++;
        end
        if (out_data.last_result !== e.last_result) begin
          $error("last_result exp %0d got %0d", e.last_result, out_data.last_result);
          errors++;
        end
      end
    end
  end

  // watchdog: cycles with no accepted item on either side
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tree_distance_sum_tb failed");
      $finish;
    end
  end

  initial begin
    tds_pkg::in_item_t it;
    no_idle = 0;
    edges_held = 0; node_count_reg = tds_pkg::NODE_COUNT_RST;
    rst_n = 1'b0; in_valid = 1'b0; in_data = '0;
    cfg_we = 1'b0; cfg_wdata = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // after reset count is 64: lone last edge gives 64 items
    it = '{end_a: 6'd0, end_b: 6'd1, last_edge: 1'b1};
    send_edge(it);
    // nodes 0 and 1 answer 1, every other node is unreached
    wait_drained();

    write_count(7'd2);
    foreach (dir_rows[i]) begin
      it = '{end_a: dir_rows[i].a, end_b: dir_rows[i].b, last_edge: dir_rows[i].last};
      send_edge(it);
    end
    write_count(7'd0);   // saturates to 2
    it = '{end_a: 6'd0, end_b: 6'd1, last_edge: 1'b1};
    send_edge(it);
    write_count(7'd127); // saturates to 64
    // overflow: 70 items, extras dropped, path 0-1-..-63 then noise
    for (int i = 0; i < 70; i++) begin
      it.end_a = (i < 63) ? NW'(i) : 6'd63;
      it.end_b = (i < 63) ? NW'(i + 1) : 6'd62;
      it.last_edge = (i == 69);
      send_edge(it);
    end
    write_count(7'd4);
    it = '{end_a: 6'd0, end_b: 6'd3, last_edge: 1'b0}; send_edge(it);
    it = '{end_a: 6'd3, end_b: 6'd0, last_edge: 1'b0}; send_edge(it);
    it = '{end_a: 6'd2, end_b: 6'd1, last_edge: 1'b0}; send_edge(it);
    it = '{end_a: 6'd3, end_b: 6'd1, last_edge: 1'b1}; send_edge(it);

    // random part: mostly small well-formed trees, two large ones
    for (int t = 0; t < 14; t++) begin
      int n;
      if (t == 11) no_idle = 1;
      n = (t == 3 || t == 10) ? $urandom_range(40, 64) : $urandom_range(2, 12);
      write_count(n[KW-1:0]);
      send_tree(n, $urandom_range(0, 3) == 0);
      if (t == 5) wait_drained(); // sender holds until all results are back
    end
    write_count(7'd64);
    send_tree(64, 1'b0);

    wait_drained();
    repeat (50) @(negedge clk);
    if (errors == 0) begin
      $display("tree_distance_sum_tb passed");
    end else begin
      $display("tree_distance_sum_tb failed");
    end
    $finish;
  end

endmodule

### files.f
src/tds_pkg.sv
src/tds_ctrl.sv
src/tds_datapath.sv
src/tree_distance_sum.sv
src/tds_checker.sv
tb/tree_distance_sum_tb.sv
